// File: rtl/swpc_pkg.sv
package swpc_pkg;

    // Fixed field widths
    localparam int HEAD_W     = 15;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int LIN_W      = 15;
    localparam int ANG_W      = 16;
    localparam int CORNER_W   = 2;
    localparam int BEARING_W  = 15;
    localparam int FRAC_BITS  = 12;

    // Angle constants
    localparam int Z_W        = 20;
    localparam logic [15:0]          TWO_PI_Q12 = 16'd25736;
    localparam logic signed [Z_W-1:0] PI_Q16     = 20'sd205887;
    localparam logic signed [Z_W-1:0] TWO_PI_Q16 = 20'sd411775;
    localparam int ATAN_LEN   = 30;
    localparam int ATAN_IDX_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TOL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIDE   = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_LINEAR_GAIN  = 15'd4096;
    localparam logic [CFG_W-1:0] RST_ANGULAR_GAIN = 15'd8192;
    localparam logic [CFG_W-1:0] RST_DIST_TOL     = 15'd819;
    localparam logic [CFG_W-1:0] RST_HEADING_TOL  = 15'd410;
    localparam logic [CFG_W-1:0] RST_SQUARE_SIDE  = 15'd4096;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_WAIT,
        S_LIN,
        S_ANG,
        S_FIN
    } state_t;

    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
    } unit_stat_t;

    // round(atan(2^-i) * 65536)
    function automatic logic [15:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [15:0] val;
        case (idx)
            5'd0:    val = 16'd51472;
            5'd1:    val = 16'd30386;
            5'd2:    val = 16'd16055;
            5'd3:    val = 16'd8150;
            5'd4:    val = 16'd4091;
            5'd5:    val = 16'd2047;
            5'd6:    val = 16'd1024;
            5'd7:    val = 16'd512;
            5'd8:    val = 16'd256;
            5'd9:    val = 16'd128;
            5'd10:   val = 16'd64;
            5'd11:   val = 16'd32;
            5'd12:   val = 16'd16;
            5'd13:   val = 16'd8;
            5'd14:   val = 16'd4;
            5'd15:   val = 16'd2;
            5'd16:   val = 16'd1;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/swpc_pose_if.sv
interface swpc_pose_if #(
    parameter int COORD_WIDTH = 16
);
    import swpc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pose_x;
    logic signed [COORD_WIDTH-1:0] pose_y;
    logic signed [HEAD_W-1:0]      pose_heading;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                    output ready);
endinterface

// File: rtl/swpc_cmd_if.sv
interface swpc_cmd_if;
    import swpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LIN_W-1:0]        linear_command;
    logic signed [ANG_W-1:0] angular_command;
    logic [CORNER_W-1:0]     corner_index;
    logic                    corner_reached;

    modport source (output valid, output linear_command, output angular_command,
                    output corner_index, output corner_reached, input ready);
    modport sink   (input valid, input linear_command, input angular_command,
                    input corner_index, input corner_reached, output ready);
endinterface

// File: rtl/swpc_mul.sv
module swpc_mul #(
    parameter int MW = 18
) (
    input  logic                   clk,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] prod
);
    logic signed [2*MW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

// File: rtl/swpc_isqrt.sv
module swpc_isqrt #(
    parameter int DW = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  swpc_pkg::unit_ctrl_t     ctrl,
    input  logic [2*DW-1:0]          radicand,
    output swpc_pkg::unit_stat_t     stat,
    output logic [DW-1:0]            root
);
    import swpc_pkg::*;

    localparam int SQW   = 2 * DW;
    localparam int CNT_W = $clog2(DW + 1);

    logic [SQW-1:0]   rad_reg;
    logic [DW:0]      rem_reg;
    logic [DW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DW+2:0] rem_t;
    logic [DW+2:0] trial;
    logic          ge;
    logic [DW+2:0] rem_sub;

    // One result bit per cycle: bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_t   = {rem_reg, rad_reg[SQW-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        ge      = (rem_t >= trial);
        rem_sub = ge ? (rem_t - trial) : rem_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQW-3:0], 2'b00};
            rem_reg  <= rem_sub[DW:0];
            root_reg <= {root_reg[DW-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign root      = root_reg;
endmodule

// File: rtl/swpc_cordic.sv
module swpc_cordic #(
    parameter int DW           = 17,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swpc_pkg::unit_ctrl_t               ctrl,
    input  logic signed [DW-1:0]               dx,
    input  logic signed [DW-1:0]               dy,
    output swpc_pkg::unit_stat_t               stat,
    output logic [swpc_pkg::BEARING_W-1:0]     bearing
);
    import swpc_pkg::*;

    localparam int N  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int XW = DW + FRAC_BITS + 2;
    localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(N - 1);

    logic signed [XW-1:0]   x_reg;
    logic signed [XW-1:0]   y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic                   zero_reg;
    logic [ATAN_IDX_W-1:0]  cnt_reg;
    logic                   busy_reg;

    logic signed [XW-1:0]  x0;
    logic signed [XW-1:0]  y0;
    logic signed [XW-1:0]  xs;
    logic signed [XW-1:0]  ys;
    logic signed [Z_W-1:0] angle;
    logic signed [Z_W-1:0] zw1;
    logic signed [Z_W-1:0] zw2;
    logic signed [Z_W-1:0] zrnd;
    logic [15:0]           r16;
    logic [15:0]           r16w;

    always_comb
    begin
        x0    = {{2{dx[DW-1]}}, dx, {FRAC_BITS{1'b0}}};
        y0    = {{2{dy[DW-1]}}, dy, {FRAC_BITS{1'b0}}};
        xs    = x_reg >>> cnt_reg;
        ys    = y_reg >>> cnt_reg;
        angle = $signed({{(Z_W-16){1'b0}}, atan_q16(cnt_reg)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            zero_reg <= (dx == '0) && (dy == '0);
            // turn a left-half-plane vector by pi first
            if (dx[DW-1])
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= PI_Q16;
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[XW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + angle;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - angle;
            end
        end
    end

    // Wrap into [0, 2pi) in Q16, round half up to Q4.12, wrap once more
    always_comb
    begin
        zw1  = z_reg[Z_W-1] ? (z_reg + TWO_PI_Q16) : z_reg;
        zw2  = (zw1 >= TWO_PI_Q16) ? (zw1 - TWO_PI_Q16) : zw1;
        zrnd = zw2 + 20'sd8;
        r16  = zrnd[Z_W-1:4];
        r16w = (r16 >= TWO_PI_Q12) ? (r16 - TWO_PI_Q12) : r16;
    end

    assign stat.busy = busy_reg;
    assign bearing   = zero_reg ? '0 : r16w[BEARING_W-1:0];
endmodule

// File: rtl/square_waypoint_p_controller.sv
// Square-path proportional waypoint follower. Each pose request (x, y, yaw) yields one
// command request: a linear command from the distance to the current square corner, an
// angular command from the heading error (held at zero once the error first falls under
// heading_tolerance), the corner targeted after the tick and a flag set on the tick that
// advanced to the next corner. The iterative square root yields D = max(COORD_WIDTH, 16) + 1
// result bits and the CORDIC runs N = min(CORDIC_STEPS, 30) vectoring steps; both run side
// by side, and one shared registered multiplier forms the squares and the gain products.
// A finished command waits in an output register, so the next pose is taken while it is
// pending. Configuration writes are taken at any time but belong to idle periods; indexes
// beyond the last register are ignored.
module square_waypoint_p_controller #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    swpc_pose_if.sink                        pose,
    swpc_cmd_if.source                       cmd,
    input  logic                             cfg_write,
    input  logic [swpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swpc_pkg::CFG_W-1:0]       cfg_data
);
    import swpc_pkg::*;

    localparam int DW  = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
    localparam int MW  = DW + 1;
    localparam int PW  = 2 * MW;
    localparam int SQW = 2 * DW;

    // Configuration
    logic [CFG_W-1:0] lin_gain_reg;
    logic [CFG_W-1:0] ang_gain_reg;
    logic [CFG_W-1:0] dist_tol_reg;
    logic [CFG_W-1:0] head_tol_reg;
    logic [CFG_W-1:0] side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg <= RST_LINEAR_GAIN;
            ang_gain_reg <= RST_ANGULAR_GAIN;
            dist_tol_reg <= RST_DIST_TOL;
            head_tol_reg <= RST_HEADING_TOL;
            side_reg     <= RST_SQUARE_SIDE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LINEAR_GAIN:  lin_gain_reg <= cfg_data;
                CFG_ANGULAR_GAIN: ang_gain_reg <= cfg_data;
                CFG_DIST_TOL:     dist_tol_reg <= cfg_data;
                CFG_HEADING_TOL:  head_tol_reg <= cfg_data;
                CFG_SQUARE_SIDE:  side_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer
    state_t state_reg;
    state_t state_next;

    logic                   out_valid_reg;
    logic                   out_free;
    logic [CORNER_W-1:0]    corner_reg;
    logic [CORNER_W-1:0]    corner_next;
    logic                   held_reg;
    logic                   held_next;
    logic                   reached;
    logic                   in_accept;
    logic                   out_load;

    unit_ctrl_t sq_ctrl;
    unit_ctrl_t co_ctrl;
    unit_stat_t sq_stat;
    unit_stat_t co_stat;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    // Captured pose
    logic signed [COORD_WIDTH-1:0] px_reg;
    logic signed [COORD_WIDTH-1:0] py_reg;
    logic signed [15:0]            yaw_reg;
    logic signed [15:0]            yaw_wrap;

    logic [PW-1:0]       acc_reg;
    logic [LIN_W-1:0]    lin_reg;

    logic signed [DW-1:0] tx;
    logic signed [DW-1:0] ty;
    logic signed [DW-1:0] px_ext;
    logic signed [DW-1:0] py_ext;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [PW-1:0]        sum_sq;
    logic [DW-1:0]        dist_root;
    logic [BEARING_W-1:0] bearing;

    logic signed [15:0]   err;
    logic [15:0]          aerr;
    logic                 head_ok;
    logic                 dist_ok;
    logic [PW-1:0]        lin_full;
    logic signed [PW-1:0] ang_full;
    logic [LIN_W-1:0]     lin_sat;
    logic signed [ANG_W-1:0] ang_sat;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pose.valid) state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_SUM;
            S_SUM:  state_next = S_WAIT;
            S_WAIT: if (!sq_stat.busy && !co_stat.busy) state_next = S_LIN;
            S_LIN:  state_next = S_ANG;
            S_ANG:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pose.ready    = 1'b0;
        sq_ctrl.start = 1'b0;
        co_ctrl.start = 1'b0;
        out_load      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            S_IDLE: pose.ready = 1'b1;
            S_SQX:
            begin
                mul_a = MW'(dx);
                mul_b = MW'(dx);
            end
            S_SQY:
            begin
                mul_a = MW'(dy);
                mul_b = MW'(dy);
            end
            S_SUM:
            begin
                sq_ctrl.start = 1'b1;
                co_ctrl.start = 1'b1;
            end
            S_LIN:
            begin
                mul_a = $signed({1'b0, dist_root});
                mul_b = $signed({{(MW-CFG_W){1'b0}}, lin_gain_reg});
            end
            S_ANG:
            begin
                mul_a = $signed({{(MW-16){err[15]}}, err});
                mul_b = $signed({{(MW-CFG_W){1'b0}}, ang_gain_reg});
            end
            S_FIN:
            begin
                // hold the angular product while the command waits
                mul_a    = $signed({{(MW-16){err[15]}}, err});
                mul_b    = $signed({{(MW-CFG_W){1'b0}}, ang_gain_reg});
                out_load = out_free;
            end
            default: ;
        endcase
    end

    assign in_accept = pose.valid && pose.ready;
    assign out_free  = !out_valid_reg || cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            corner_reg    <= '0;
            held_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                corner_reg    <= corner_next;
                held_reg      <= held_next;
            end
            else if (cmd.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_comb
    begin
        yaw_wrap = $signed({pose.pose_heading[HEAD_W-1], pose.pose_heading});
        if (pose.pose_heading[HEAD_W-1])
            yaw_wrap = yaw_wrap + $signed(TWO_PI_Q12);
    end

    always_comb
    begin
        tx = (corner_reg == 2'd1 || corner_reg == 2'd2) ?
             $signed({{(DW-CFG_W){1'b0}}, side_reg}) : '0;
        ty = (corner_reg == 2'd0 || corner_reg == 2'd1) ?
             $signed({{(DW-CFG_W){1'b0}}, side_reg}) : '0;
        px_ext = {{(DW-COORD_WIDTH){px_reg[COORD_WIDTH-1]}}, px_reg};
        py_ext = {{(DW-COORD_WIDTH){py_reg[COORD_WIDTH-1]}}, py_reg};
        dx     = tx - px_ext;
        dy     = ty - py_ext;
        sum_sq = acc_reg + PW'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg  <= pose.pose_x;
            py_reg  <= pose.pose_y;
            yaw_reg <= yaw_wrap;
        end
        if (state_reg == S_SQY)
            acc_reg <= PW'(prod);
        if (state_reg == S_ANG)
            lin_reg <= lin_sat;
    end

    swpc_mul #(
        .MW (MW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    swpc_isqrt #(
        .DW (DW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sq_ctrl),
        .radicand (sum_sq[SQW-1:0]),
        .stat     (sq_stat),
        .root     (dist_root)
    );

    swpc_cordic #(
        .DW           (DW),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (co_ctrl),
        .dx      (dx),
        .dy      (dy),
        .stat    (co_stat),
        .bearing (bearing)
    );

    // Heading error is forced to zero while the heading is held
    always_comb
    begin
        err     = held_reg ? 16'sd0 : ($signed({1'b0, bearing}) - yaw_reg);
        aerr    = err[15] ? 16'(-err) : 16'(err);
        head_ok = aerr < {1'b0, head_tol_reg};
        dist_ok = dist_root < {{(DW-CFG_W){1'b0}}, dist_tol_reg};
        reached = dist_ok && head_ok;

        held_next = held_reg;
        if (!held_reg && head_ok)
            held_next = 1'b1;
        if (reached)
            held_next = 1'b0;
        corner_next = reached ? (corner_reg + 2'd1) : corner_reg;
    end

    // Round half up, then saturate
    always_comb
    begin
        lin_full = (PW'(prod) + PW'(2048)) >> FRAC_BITS;
        lin_sat  = (lin_full[PW-1:LIN_W] != '0) ? {LIN_W{1'b1}} : lin_full[LIN_W-1:0];

        ang_full = (prod + $signed(PW'(2048))) >>> FRAC_BITS;
        if (held_reg)
            ang_sat = '0;
        else if (ang_full[PW-1:ANG_W-1] == '0 || ang_full[PW-1:ANG_W-1] == '1)
            ang_sat = ang_full[ANG_W-1:0];
        else if (ang_full[PW-1])
            ang_sat = {1'b1, {(ANG_W-1){1'b0}}};
        else
            ang_sat = {1'b0, {(ANG_W-1){1'b1}}};
    end

    logic [LIN_W-1:0]        lin_out_reg;
    logic signed [ANG_W-1:0] ang_out_reg;
    logic [CORNER_W-1:0]     corner_out_reg;
    logic                    reached_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            lin_out_reg     <= lin_reg;
            ang_out_reg     <= ang_sat;
            corner_out_reg  <= corner_next;
            reached_out_reg <= reached;
        end
    end

    assign cmd.valid           = out_valid_reg;
    assign cmd.linear_command  = lin_out_reg;
    assign cmd.angular_command = ang_out_reg;
    assign cmd.corner_index    = corner_out_reg;
    assign cmd.corner_reached  = reached_out_reg;

    // Assertions
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        pose.ready |-> (!sq_stat.busy && !co_stat.busy))
        else $error("pose request taken while a shared unit is busy");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && reached) |=>
            (!held_reg && corner_reg == $past(corner_reg) + 2'd1))
        else $error("corner advance did not clear the heading latch");

    a_corner_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (cmd.corner_index == corner_reg))
        else $error("pending command disagrees with corner state");
endmodule
